// ===== hdl/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

  localparam int unsigned IN_W   = 8;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned MAX_UNITS = 4;

  localparam logic [20:0]       MAX_CODE     = 21'h10FFFF;
  localparam logic [20:0]       SUPP_BASE    = 21'h010000;
  localparam logic [UNIT_W-1:0] BMP_MAX      = 16'hFFFF;
  localparam logic [UNIT_W-1:0] SURR_LO_END  = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_HI_END  = 16'hE000;
  localparam logic [UNIT_W-1:0] HIGH_SURR    = 16'hD800;
  localparam logic [UNIT_W-1:0] LOW_SURR     = 16'hDC00;

  typedef logic [1:0] flush_cnt_t;
  typedef logic [2:0] burst_cnt_t;

  typedef struct packed {
    flush_cnt_t        cnt;
    logic [UNIT_W-1:0] u1;
    logic [UNIT_W-1:0] u0;
  } flush_t;

  typedef struct packed {
    burst_cnt_t                        cnt;
    logic [MAX_UNITS-1:0][UNIT_W-1:0] unit;
  } burst_t;

endpackage

`default_nettype wire

// ===== hdl/u8u16_flush.sv =====
`default_nettype none

module u8u16_flush
  import u8u16_pkg::*;
(
  input  wire logic [ACC_W-1:0] code,
  output flush_t                res
);

  logic        over;
  logic [20:0] off;

  assign over = (|code[ACC_W-1:21]) || (code[20:0] > MAX_CODE);
  assign off  = code[20:0] - SUPP_BASE;

  always_comb begin
    res.cnt = 2'd0;
    res.u0  = code[UNIT_W-1:0];
    res.u1  = '0;
    if (over) begin
      res.cnt = 2'd0;
    end else if (code[20:0] > {5'd0, BMP_MAX}) begin
      res.cnt = 2'd2;
      res.u0  = HIGH_SURR + {6'd0, off[19:10]};
      res.u1  = LOW_SURR + {6'd0, off[9:0]};
    end else if (code[UNIT_W-1:0] < SURR_LO_END || code[UNIT_W-1:0] >= SURR_HI_END) begin
      res.cnt = 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u8u16_step.sv =====
`default_nettype none

module u8u16_step
  import u8u16_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic [IN_W-1:0] in_byte,
  input  wire logic            in_eos,
  output burst_t               burst
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             pend_r, pend_nxt;
  logic [ACC_W-1:0] acc_new;
  logic             is_cont;
  flush_t           f_old, f_new;
  flush_cnt_t       c_old, c_new;

  assign is_cont = (in_byte[7:6] == 2'b10);

  always_comb begin
    if (is_cont) begin
      acc_new = {acc_r[ACC_W-7:0], in_byte[5:0]};
    end else if (!in_byte[7]) begin
      acc_new = {{(ACC_W-IN_W){1'b0}}, in_byte};
    end else if (in_byte[7:5] == 3'b110) begin
      acc_new = {{(ACC_W-5){1'b0}}, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      acc_new = {{(ACC_W-4){1'b0}}, in_byte[3:0]};
    end else begin
      acc_new = {{(ACC_W-3){1'b0}}, in_byte[2:0]};
    end
  end

  u8u16_flush u_flush_old (
    .code (acc_r),
    .res  (f_old)
  );

  u8u16_flush u_flush_new (
    .code (acc_new),
    .res  (f_new)
  );

  assign c_old = (pend_r && !is_cont) ? f_old.cnt : 2'd0;
  assign c_new = in_eos ? f_new.cnt : 2'd0;

  always_comb begin
    burst.cnt     = {1'b0, c_old} + {1'b0, c_new};
    burst.unit[0] = f_old.u0;
    burst.unit[1] = f_old.u1;
    burst.unit[2] = f_new.u0;
    burst.unit[3] = f_new.u1;
    case (c_old)
      2'd0: begin
        burst.unit[0] = f_new.u0;
        burst.unit[1] = f_new.u1;
      end
      2'd1: begin
        burst.unit[1] = f_new.u0;
        burst.unit[2] = f_new.u1;
      end
      default: begin
        burst.unit[2] = f_new.u0;
        burst.unit[3] = f_new.u1;
      end
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    if (in_fire) begin
      if (in_eos) begin
        acc_nxt  = '0;
        pend_nxt = 1'b0;
      end else begin
        acc_nxt  = acc_new;
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u8u16_outbuf.sv =====
`default_nettype none

module u8u16_outbuf
  import u8u16_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire burst_t            burst,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [UNIT_W-1:0]      out_unit,
  output logic                   out_last
);

  logic [MAX_UNITS-1:0][UNIT_W-1:0] unit_r, unit_nxt;
  burst_cnt_t                       cnt_r, cnt_nxt;
  burst_cnt_t                       ptr_r, ptr_nxt;
  burst_cnt_t                       ptr_inc;

  assign ptr_inc   = ptr_r + 3'd1;
  assign out_valid = (ptr_r != cnt_r);
  assign out_unit  = unit_r[ptr_r[1:0]];
  assign out_last  = (ptr_inc == cnt_r);
  assign in_ready  = !out_valid || (out_ready && out_last);

  always_comb begin
    unit_nxt = unit_r;
    cnt_nxt  = cnt_r;
    ptr_nxt  = ptr_r;
    if (in_fire) begin
      unit_nxt = burst.unit;
      cnt_nxt  = burst.cnt;
      ptr_nxt  = '0;
    end else if (out_valid && out_ready) begin
      ptr_nxt = ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r <= cnt_r) && (cnt_r <= 3'd4))
    else $error("Unit pointer ran past the burst count.");

  a_ready_one_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> ((cnt_r - ptr_r) <= 3'd1))
    else $error("Input taken while more than one unit was still queued.");

  a_burst_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && burst.cnt != 3'd0) |=> (out_valid && ptr_r == 3'd0))
    else $error("A loaded burst did not present its first unit.");

  a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last && !in_fire) |=> !out_valid)
    else $error("Output still valid after the final unit of a burst.");

endmodule

`default_nettype wire

// ===== hdl/utf8_to_utf16_converter_top.sv =====
`default_nettype none

// A UTF-16 unit appears on the output in the cycle after the byte that releases it is accepted.
// Throughput: one byte per cycle while each byte gives at most one unit and out_tready is high.
// A byte that gives n units (up to four) holds off the next byte until the last unit of its burst is taken,
// set by the single output buffer that drains its burst one beat a cycle while out_tready is high.
// Reset (rst_n low at a clock edge) clears the accumulator, the pending flag and the queue.
module utf8_to_utf16_converter_top
  import u8u16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] utf16_unit
  output logic             out_tlast   // run_last
);

  logic   in_fire;
  burst_t burst;

  assign in_fire = in_tvalid && in_tready;

  u8u16_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_eos  (in_tlast),
    .burst   (burst)
  );

  u8u16_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .burst     (burst),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_unit  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import u8u16_pkg::*;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
  } utf16_beat_t;

  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [UNIT_W-1:0] out_tdata;
  logic              out_tlast;

  utf16_beat_t       units_due [$];
  logic [ACC_W-1:0]  code_acc = '0;
  logic              code_pending = 1'b0;
  int                errors = 0;
  int                bytes_sent = 0;
  int                stall_left = 0;
  bit                no_idle = 1'b0;
  bit                hold_request = 1'b0;

  utf8_to_utf16_converter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int encode_value(input logic [ACC_W-1:0] v,
                                      output logic [UNIT_W-1:0] hi,
                                      output logic [UNIT_W-1:0] lo);
    logic [ACC_W-1:0] off;
    hi = v[UNIT_W-1:0];
    lo = '0;
    if (v > {11'd0, MAX_CODE}) return 0;
    if (v > {16'd0, BMP_MAX}) begin
      off = v - {11'd0, SUPP_BASE};
      hi  = HIGH_SURR + {6'd0, off[19:10]};
      lo  = LOW_SURR + {6'd0, off[9:0]};
      return 2;
    end
    if (v[UNIT_W-1:0] >= SURR_LO_END && v[UNIT_W-1:0] < SURR_HI_END) return 0;
    return 1;
  endfunction

  function automatic void predict_units(input logic [IN_W-1:0] b, input logic eos);
    logic [UNIT_W-1:0] units [0:3];
    logic [UNIT_W-1:0] hi;
    logic [UNIT_W-1:0] lo;
    int                n;
    int                k;
    n = 0;
    if (b >= 8'h80 && b <= 8'hBF) begin
      code_acc = {code_acc[ACC_W-7:0], b[5:0]};
    end else begin
      if (code_pending) begin
        k = encode_value(code_acc, hi, lo);
        if (k > 0) begin
          units[n] = hi;
          n++;
        end
        if (k > 1) begin
          units[n] = lo;
          n++;
        end
      end
      if (b <= 8'h7F) code_acc = {24'd0, b};
      else if (b <= 8'hDF) code_acc = {27'd0, b[4:0]};
      else if (b <= 8'hEF) code_acc = {28'd0, b[3:0]};
      else code_acc = {29'd0, b[2:0]};
    end
    code_pending = 1'b1;
    if (eos) begin
      k = encode_value(code_acc, hi, lo);
      if (k > 0) begin
        units[n] = hi;
        n++;
      end
      if (k > 1) begin
        units[n] = lo;
        n++;
      end
      code_acc = '0;
      code_pending = 1'b0;
    end
    for (int i = 0; i < n; i++) units_due.push_back('{unit: units[i], last: (i == n - 1)});
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int receiver_stall();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [20:0] random_code_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 21'($urandom_range(1, 'h7F));
    if (r < 45) return 21'($urandom_range('h80, 'h7FF));
    if (r < 65) return 21'($urandom_range('h800, 'hFFFF));
    if (r < 90) return 21'($urandom_range('h10000, 'h10FFFF));
    if (r < 95) return 21'($urandom_range('hD800, 'hDFFF));
    return 21'($urandom_range('h110000, 'h1FFFFF));
  endfunction

  task automatic send_byte(input logic [IN_W-1:0] b, input logic eos);
    int gap;
    gap = no_idle ? 0 : sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_units(b, eos);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [IN_W-1:0] text [$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_code_point(input logic [20:0] cp, input logic eos);
    if (cp < 21'h80) begin
      send_byte(cp[7:0], eos);
    end else if (cp < 21'h800) begin
      send_byte({3'b110, cp[10:6]}, 1'b0);
      send_byte({2'b10, cp[5:0]}, eos);
    end else if (cp < 21'h10000) begin
      send_byte({4'b1110, cp[15:12]}, 1'b0);
      send_byte({2'b10, cp[11:6]}, 1'b0);
      send_byte({2'b10, cp[5:0]}, eos);
    end else begin
      send_byte({5'b11110, cp[20:18]}, 1'b0);
      send_byte({2'b10, cp[17:12]}, 1'b0);
      send_byte({2'b10, cp[11:6]}, 1'b0);
      send_byte({2'b10, cp[5:0]}, eos);
    end
  endtask

  task automatic send_random_strings(input int count);
    int stop_at;
    int chars;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      chars = $urandom_range(1, 6);
      for (int i = 0; i < chars; i++) send_code_point(random_code_point(), i == chars - 1);
    end
  endtask

  task automatic test_directed();
    logic [IN_W-1:0] mixed [$];
    logic [IN_W-1:0] stray [$];
    logic [IN_W-1:0] edges [$];
    mixed = '{8'h01, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
              8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF1};
    stray = '{8'h80};
    edges = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80,
              8'hED, 8'hA0, 8'h80, 8'hC2, 8'hFF};
    send_string(mixed);
    send_string(stray);
    send_string(edges);
  endtask

  task automatic test_well_formed();
    send_random_strings(120);
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    send_random_strings(40);
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 8; i++) send_code_point(21'($urandom_range('h10000, 'h10FFFF)), i == 7);
    no_idle = 1'b0;
  endtask

  task automatic test_malformed_noise();
    int stop_at;
    int run;
    stop_at = bytes_sent + 60;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        run = $urandom_range(3, 8);
        for (int i = 0; i < run; i++) begin
          send_byte(8'($urandom_range('h80, 'hBF)), i == run - 1 && $urandom_range(0, 1) == 1);
        end
      end else begin
        send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
      end
    end
    send_byte(8'($urandom_range(1, 255)), 1'b1);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        stall_left   = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
        stall_left = receiver_stall();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_units
    utf16_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (units_due.size() == 0) begin
        report_mismatch($sformatf("unit %h with nothing expected", out_tdata));
      end else begin
        want = units_due.pop_front();
        if (out_tdata !== want.unit)
          report_mismatch($sformatf("unit %h, expected %h", out_tdata, want.unit));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b on unit %h",
                                    out_tlast, want.last, want.unit));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[utf8_to_utf16_converter_top] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_well_formed();
    test_steady_stream();
    test_output_backpressure();
    test_malformed_noise();
    in_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[utf8_to_utf16_converter_top] OK");
    end else begin
      $display("[utf8_to_utf16_converter_top] ERROR");
    end
    $finish;
  end

endmodule
